[sv/force_gated_contact_point_top_assert.svh]
// Assertion macros for the force gated contact point block.
// Expects clk_i and rst_ni in the scope of use.
`ifndef FORCE_GATED_CONTACT_POINT_TOP_ASSERT_SVH
`define FORCE_GATED_CONTACT_POINT_TOP_ASSERT_SVH

// Same-cycle property.
`define FGCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent, consequence in the next cycle.
`define FGCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/fgcp_pkg.sv]
// Package for the force gated contact point block: widths, codes, types and
// the rotation matrix entry function. No dependencies.
package fgcp_pkg;

  localparam int unsigned CFG_W           = 32;
  localparam int unsigned IDX_W           = 3;
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned COEF_W          = 31;
  localparam int unsigned NUM_COEF        = 9;
  localparam int unsigned PT_W            = 33;
  localparam int unsigned PROD_W          = 64;
  localparam int unsigned SUM_W           = 66;
  localparam int unsigned FRAC_SH         = 29;

  localparam logic signed [COEF_W-1:0] ONE_Q29 = 31'sh2000_0000;
  localparam logic [CFG_W-1:0]  THR_RESET = 32'h0000_8000;
  localparam logic signed [15:0] ROT_W_RESET = 16'sh4000;

  typedef enum logic [IDX_W-1:0] {
    CFG_THR   = 3'd0,
    CFG_ROT_W = 3'd1,
    CFG_ROT_X = 3'd2,
    CFG_ROT_Y = 3'd3,
    CFG_ROT_Z = 3'd4,
    CFG_OFF_X = 3'd5,
    CFG_OFF_Y = 3'd6,
    CFG_OFF_Z = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CT_DIAG,
    CT_SUM,
    CT_DIFF
  } ct_mode_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_NORM,
    CS_LOAD,
    CS_DIV
  } coef_state_e;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  // Unnormalized rotation matrix entry k (row major), scaled by n.
  function automatic logic signed [35:0] cterm(input logic [3:0] k, input quat_t q,
                                               input logic [32:0] n);
    ct_mode_e           mode;
    logic signed [15:0] a1, b1, a2, b2;
    logic signed [31:0] p1, p2;
    logic signed [35:0] s1, s2, nn, r;
    mode = CT_DIAG;
    a1 = q.x; b1 = q.x; a2 = q.y; b2 = q.y;
    case (k)
      4'd0: begin mode = CT_DIAG; a1 = q.y; b1 = q.y; a2 = q.z; b2 = q.z; end
      4'd1: begin mode = CT_DIFF; a1 = q.x; b1 = q.y; a2 = q.z; b2 = q.w; end
      4'd2: begin mode = CT_SUM;  a1 = q.x; b1 = q.z; a2 = q.y; b2 = q.w; end
      4'd3: begin mode = CT_SUM;  a1 = q.x; b1 = q.y; a2 = q.z; b2 = q.w; end
      4'd4: begin mode = CT_DIAG; a1 = q.x; b1 = q.x; a2 = q.z; b2 = q.z; end
      4'd5: begin mode = CT_DIFF; a1 = q.y; b1 = q.z; a2 = q.x; b2 = q.w; end
      4'd6: begin mode = CT_DIFF; a1 = q.x; b1 = q.z; a2 = q.y; b2 = q.w; end
      4'd7: begin mode = CT_SUM;  a1 = q.y; b1 = q.z; a2 = q.x; b2 = q.w; end
      default: begin mode = CT_DIAG; a1 = q.x; b1 = q.x; a2 = q.y; b2 = q.y; end
    endcase
    p1 = a1 * b1;
    p2 = a2 * b2;
    s1 = 36'(p1);
    s2 = 36'(p2);
    nn = $signed({3'b000, n});
    case (mode)
      CT_SUM:  r = (s1 + s2) <<< 1;
      CT_DIFF: r = (s1 - s2) <<< 1;
      default: r = nn - ((s1 + s2) <<< 1);
    endcase
    return r;
  endfunction

endpackage

[sv/fgcp_in_if.sv]
// Input channel: valid/ready plus force and tip position payload.
// No dependencies.
interface fgcp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic signed [31:0] tip_x;
  logic signed [31:0] tip_y;
  logic signed [31:0] tip_z;

  modport source (output valid, force_x, force_y, force_z, tip_x, tip_y, tip_z,
                  input ready);
  modport sink   (input valid, force_x, force_y, force_z, tip_x, tip_y, tip_z,
                  output ready);
endinterface

[sv/fgcp_out_if.sv]
// Output channel: valid/ready plus contact point payload.
// Width follows COORD_WIDTH.
interface fgcp_out_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

[sv/fgcp_coef.sv]
// Rotation coefficient generator: builds the normalized Q1.29 matrix from the
// base quaternion with a bit-serial divider. Depends on fgcp_pkg.
module fgcp_coef
  import fgcp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  quat_t                    quat_i,
  output logic                     busy_o,
  output logic signed [COEF_W-1:0] coef_o [NUM_COEF]
);

  coef_state_e state_q, state_d;

  logic [3:0]  k_q;
  logic [5:0]  cnt_q;
  logic [32:0] n_q;
  logic [62:0] num_q;
  logic [34:0] rem_q;
  logic [30:0] quo_q;
  logic        neg_q;
  logic signed [COEF_W-1:0] coef_q [NUM_COEF];

  logic signed [31:0] ww, xx, yy, zz;
  logic [32:0]        n_calc;
  logic signed [35:0] ct;
  logic [35:0]        ct_mag;
  logic [62:0]        num_ld;
  logic [34:0]        rem_sh, dvs, rem_nx;
  logic               ge;
  logic [30:0]        quo_nx;
  logic signed [31:0] quo_s;
  logic signed [COEF_W-1:0] coef_val;
  logic               last_k, last_bit, diag;

  always_comb begin
    ww = quat_i.w * quat_i.w;
    xx = quat_i.x * quat_i.x;
    yy = quat_i.y * quat_i.y;
    zz = quat_i.z * quat_i.z;
    n_calc = 33'($unsigned(ww)) + 33'($unsigned(xx)) + 33'($unsigned(yy))
           + 33'($unsigned(zz));
    ct     = cterm(k_q, quat_i, n_q);
    ct_mag = (ct < 0) ? $unsigned(-ct) : $unsigned(ct);
    num_ld = {ct_mag[32:0], 30'b0} + {30'b0, n_q};
    rem_sh = {rem_q[33:0], num_q[62]};
    dvs    = {1'b0, n_q, 1'b0};
    ge     = rem_sh >= dvs;
    rem_nx = ge ? (rem_sh - dvs) : rem_sh;
    quo_nx = {quo_q[29:0], ge};
    quo_s  = $signed({1'b0, quo_nx});
    coef_val = neg_q ? COEF_W'(-quo_s) : COEF_W'(quo_s);
    last_k   = k_q == 4'(NUM_COEF - 1);
    last_bit = cnt_q == 6'd62;
    diag     = (k_q == 4'd0) || (k_q == 4'd4) || (k_q == 4'd8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_NORM;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: state_d = CS_IDLE;
      CS_NORM: state_d = CS_LOAD;
      CS_LOAD: begin
        if (n_q != '0) state_d = CS_DIV;
        else if (last_k) state_d = CS_IDLE;
      end
      CS_DIV: begin
        if (last_bit) state_d = last_k ? CS_IDLE : CS_LOAD;
      end
      default: state_d = CS_IDLE;
    endcase
    if (start_i) state_d = CS_NORM;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      cnt_q <= '0;
    end else begin
      case (state_q)
        CS_NORM: k_q <= '0;
        CS_LOAD: begin
          cnt_q <= '0;
          if (n_q == '0) k_q <= k_q + 4'd1;
        end
        CS_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (last_bit) k_q <= k_q + 4'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_NORM: n_q <= n_calc;
      CS_LOAD: begin
        if (n_q == '0) begin
          coef_q[k_q] <= diag ? ONE_Q29 : '0;
        end else begin
          num_q <= num_ld;
          rem_q <= '0;
          quo_q <= '0;
          neg_q <= ct < 0;
        end
      end
      CS_DIV: begin
        num_q <= {num_q[61:0], 1'b0};
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        if (last_bit) coef_q[k_q] <= coef_val;
      end
      default: ;
    endcase
  end

  assign busy_o = state_q != CS_IDLE;
  assign coef_o = coef_q;

endmodule

[sv/force_gated_contact_point_top.sv]
// An accepted input passes the stage 1 to stage 4 registers to the output.
// One item per cycle while not stalled; gated-off items leave no result.
// After reset and after every configuration write the coefficient divider
// runs through a setup step and the 9 matrix entries, with in ready low.
// Reset: asynchronous active low; registers return to their defaults.
`include "force_gated_contact_point_top_assert.svh"
module force_gated_contact_point_top
  import fgcp_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  fgcp_in_if.sink             in_i,
  fgcp_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};
  localparam logic signed [SUM_W-1:0] RND_POS = SUM_W'(1) << (FRAC_SH - 1);
  localparam logic signed [SUM_W-1:0] RND_NEG = RND_POS - SUM_W'(1);

  logic [CFG_W-1:0]   thr_q;
  quat_t              quat_q;
  logic signed [31:0] off_q [3];

  logic                     coef_busy;
  logic signed [COEF_W-1:0] coef [NUM_COEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RESET;
      quat_q.w <= ROT_W_RESET;
      quat_q.x <= '0;
      quat_q.y <= '0;
      quat_q.z <= '0;
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_THR:   thr_q    <= cfg_data_i;
        CFG_ROT_W: quat_q.w <= cfg_data_i[15:0];
        CFG_ROT_X: quat_q.x <= cfg_data_i[15:0];
        CFG_ROT_Y: quat_q.y <= cfg_data_i[15:0];
        CFG_ROT_Z: quat_q.z <= cfg_data_i[15:0];
        CFG_OFF_X: off_q[0] <= cfg_data_i;
        CFG_OFF_Y: off_q[1] <= cfg_data_i;
        CFG_OFF_Z: off_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fgcp_coef u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i),
    .quat_i  (quat_q),
    .busy_o  (coef_busy),
    .coef_o  (coef)
  );

  // Stage handshake
  logic v1_q, v2_q, v3_q, out_v_q;
  logic en1, en2, en3, en4, in_fire;

  assign en4     = !out_v_q || out_o.ready;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign in_i.ready = en1 && !coef_busy;
  assign in_fire = in_i.valid && in_i.ready;

  // Stage 1: squares and offset sum
  logic [63:0]           fsq_q [3];
  logic [63:0]           thr2_q;
  logic signed [PT_W-1:0] p1_q [3];
  logic signed [63:0]    fsq_d [3];
  logic signed [31:0]    tip [3];

  always_comb begin
    fsq_d[0] = in_i.force_x * in_i.force_x;
    fsq_d[1] = in_i.force_y * in_i.force_y;
    fsq_d[2] = in_i.force_z * in_i.force_z;
    tip[0] = in_i.tip_x;
    tip[1] = in_i.tip_y;
    tip[2] = in_i.tip_z;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      thr2_q <= 64'(thr_q) * 64'(thr_q);
      for (int i = 0; i < 3; i++) begin
        fsq_q[i] <= $unsigned(fsq_d[i]);
        p1_q[i]  <= PT_W'(tip[i]) + PT_W'(off_q[i]);
      end
    end
  end

  // Stage 2: gate and matrix products
  logic [63:0]             mag;
  logic                    gate;
  logic signed [PROD_W-1:0] prod_q [NUM_COEF];

  assign mag  = fsq_q[0] + fsq_q[1] + fsq_q[2];
  assign gate = mag > thr2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[3*i+j] <= PROD_W'(coef[3*i+j]) * PROD_W'(p1_q[j]);
        end
      end
    end
  end

  // Stage 3: row sums
  logic signed [SUM_W-1:0] sum_q [3];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= SUM_W'(prod_q[3*i]) + SUM_W'(prod_q[3*i+1]) + SUM_W'(prod_q[3*i+2]);
      end
    end
  end

  // Stage 4: round half away from zero, saturate
  logic signed [SUM_W-1:0]       rnd [3];
  logic signed [COORD_WIDTH-1:0] sat [3];
  logic signed [COORD_WIDTH-1:0] pt_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (sum_q[i] + (sum_q[i][SUM_W-1] ? RND_NEG : RND_POS)) >>> FRAC_SH;
      if (rnd[i] > SAT_HI) sat[i] = SAT_HI[COORD_WIDTH-1:0];
      else if (rnd[i] < SAT_LO) sat[i] = SAT_LO[COORD_WIDTH-1:0];
      else sat[i] = rnd[i][COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      for (int i = 0; i < 3; i++) pt_q[i] <= sat[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) v1_q    <= in_fire;
      if (en2) v2_q    <= v1_q && gate;
      if (en3) v3_q    <= v2_q;
      if (en4) out_v_q <= v3_q;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.point_x = pt_q[0];
  assign out_o.point_y = pt_q[1];
  assign out_o.point_z = pt_q[2];

  `FGCP_ASSERT(a_coef_bound, coef_busy || (coef[0] <= ONE_Q29 && coef[0] >= -ONE_Q29), "diagonal coefficient out of range")
  `FGCP_ASSERT_NEXT(a_gate_drop, v1_q && en2 && !gate, !v2_q, "gated item entered stage 2")
  `FGCP_ASSERT_NEXT(a_out_src, !out_v_q && !v3_q, !out_v_q, "result without stage 3 item")

endmodule

[tb/force_gated_contact_point_checker.sv]
// Checker for the force gated contact point block: watches the in and out
// channels, predicts contact points and compares. Depends on fgcp_pkg.
`timescale 1ns / 1ps
module force_gated_contact_point_checker
  import fgcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fgcp_in_if          in_i,
  fgcp_out_if         out_i,
  input  logic        cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          points_o
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  point_t             point_q[$];
  logic [31:0]        thr;
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] offs[3];

  assign pending_o = point_q.size();

  function automatic longint round_coef(longint c, longint n);
    longint unsigned m, q;
    m = (c < 0) ? -c : c;
    q = ((m << 30) + n) / (2 * n);
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] round_sat(logic signed [127:0] s);
    logic signed [127:0] m;
    m = (s < 0) ? -s : s;
    m = (m + (128'sd1 <<< 28)) >>> 29;
    if (s < 0) m = -m;
    if (m > 128'sd2147483647) return 32'sh7fff_ffff;
    if (m < -128'sd2147483648) return 32'sh8000_0000;
    return m[31:0];
  endfunction

  function automatic bit predict_point(logic signed [31:0] f[3],
                                       logic signed [31:0] t[3], output point_t pt);
    longint unsigned mag, a;
    longint p[3], c[3][3], m[3][3], w, x, y, z, n;
    logic signed [127:0] s;
    logic signed [31:0] r[3];
    mag = 0;
    for (int i = 0; i < 3; i++) begin
      a = (f[i] < 0) ? -longint'(f[i]) : longint'(f[i]);
      mag += a * a;
    end
    if (!(mag > longint'(thr) * longint'(thr))) return 0;
    for (int i = 0; i < 3; i++) p[i] = longint'(t[i]) + longint'(offs[i]);
    w = qw; x = qx; y = qy; z = qz;
    n = w*w + x*x + y*y + z*z;
    c[0][0] = n - 2*(y*y + z*z); c[0][1] = 2*(x*y - z*w); c[0][2] = 2*(x*z + y*w);
    c[1][0] = 2*(x*y + z*w); c[1][1] = n - 2*(x*x + z*z); c[1][2] = 2*(y*z - x*w);
    c[2][0] = 2*(x*z - y*w); c[2][1] = 2*(y*z + x*w); c[2][2] = n - 2*(x*x + y*y);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = (n == 0) ? ((i == j) ? (64'sd1 <<< 29) : 0) : round_coef(c[i][j], n);
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int j = 0; j < 3; j++) s += 128'(m[i][j]) * 128'(p[j]);
      r[i] = round_sat(s);
    end
    pt.x = r[0]; pt.y = r[1]; pt.z = r[2];
    return 1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    point_t pt, got;
    logic signed [31:0] f[3], t[3];
    if (!rst_ni) begin
      thr <= THR_RESET; qw <= ROT_W_RESET; qx <= '0; qy <= '0; qz <= '0;
      offs[0] <= '0; offs[1] <= '0; offs[2] <= '0;
      errors_o <= 0; points_o <= 0;
      point_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_THR:   thr <= cfg_data_i;
          CFG_ROT_W: qw <= cfg_data_i[15:0];
          CFG_ROT_X: qx <= cfg_data_i[15:0];
          CFG_ROT_Y: qy <= cfg_data_i[15:0];
          CFG_ROT_Z: qz <= cfg_data_i[15:0];
          CFG_OFF_X: offs[0] <= cfg_data_i;
          CFG_OFF_Y: offs[1] <= cfg_data_i;
          CFG_OFF_Z: offs[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        f[0] = in_i.force_x; f[1] = in_i.force_y; f[2] = in_i.force_z;
        t[0] = in_i.tip_x; t[1] = in_i.tip_y; t[2] = in_i.tip_z;
        if (predict_point(f, t, pt)) point_q.push_back(pt);
      end
      if (out_i.valid && out_i.ready) begin
        points_o <= points_o + 1;
        got.x = out_i.point_x; got.y = out_i.point_y; got.z = out_i.point_z;
        if (point_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected point %h %h %h", got.x, got.y, got.z);
          errors_o <= errors_o + 1;
        end else begin
          pt = point_q.pop_front();
          if (pt != got) begin
            if (errors_o < 10)
              $display("point mismatch exp %h %h %h got %h %h %h",
                       pt.x, pt.y, pt.z, got.x, got.y, got.z);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

[tb/force_gated_contact_point_top_tb.sv]
// Testbench top for the force gated contact point block: clock, reset,
// configuration phases, directed and random stimulus, verdict. Uses the checker.
`timescale 1ns / 1ps
module force_gated_contact_point_top_tb;
  import fgcp_pkg::*;

  localparam int LIMIT = 20000;

  logic clk_i, rst_ni, cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  int errors, pending, points, idle_cycles, sent, hold;
  bit calm, timeout;

  fgcp_in_if  in_if ();
  fgcp_out_if #(.COORD_WIDTH(32)) out_if ();

  force_gated_contact_point_top DUT (
    .clk_i, .rst_ni, .in_i(in_if), .out_o(out_if),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  force_gated_contact_point_checker u_checker (
    .clk_i, .rst_ni, .in_i(in_if), .out_i(out_if),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .points_o(points)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    in_if.valid = 0; in_if.force_x = 0; in_if.force_y = 0; in_if.force_z = 0;
    in_if.tip_x = 0; in_if.tip_y = 0; in_if.tip_z = 0;
    out_if.ready = 0; cfg_we_i = 0; cfg_idx_i = '0; cfg_data_i = '0;
    rst_ni = 0; hold = 0; calm = 0; timeout = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (hold > 0) begin
      hold <= hold - 1;
      out_if.ready <= 0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LIMIT) begin
      timeout = 1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(4095) - 2048;
      4: return ($urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000) * $urandom_range(9);
      default: return $urandom;
    endcase
  endfunction

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain_idle();
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic send_sample(logic [31:0] fx, fy, fz, tx, ty, tz);
    if (!calm)
      while ($urandom_range(99) < 6) begin
        in_if.valid <= 0;
        @(posedge clk_i);
      end
    in_if.valid <= 1;
    in_if.force_x <= fx; in_if.force_y <= fy; in_if.force_z <= fz;
    in_if.tip_x <= tx; in_if.tip_y <= ty; in_if.tip_z <= tz;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic end_burst();
    in_if.valid <= 0;
    drain_idle();
  endtask

  task automatic set_pose(logic [31:0] th, logic [15:0] w, x, y, z,
                          logic [31:0] ox, oy, oz);
    cfg_write(CFG_THR, th); cfg_write(CFG_ROT_W, {16'h0, w});
    cfg_write(CFG_ROT_X, {16'h0, x}); cfg_write(CFG_ROT_Y, {16'h0, y});
    cfg_write(CFG_ROT_Z, {16'h0, z}); cfg_write(CFG_OFF_X, ox);
    cfg_write(CFG_OFF_Y, oy); cfg_write(CFG_OFF_Z, oz);
  endtask

  initial begin
    logic [31:0] th;
    sent = 0; idle_cycles = 0;
    @(posedge rst_ni);
    // defaults: identity, threshold 0.5
    send_sample(32'h8000, 0, 0, 32'h1234_5678, 32'hdead_beef, 32'h7fff_ffff);
    send_sample(32'h8001, 0, 0, 32'h1234_5678, 32'hdead_beef, 32'h7fff_ffff);
    send_sample(0, 0, 0, 1, 2, 3);
    send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 0);
    send_sample(32'h7fff_ffff, 32'hffff_ffff, 1, 32'hffff_ffff, 1, 32'h8000_0000);
    end_burst();
    // zero quaternion, extreme offsets, max threshold
    set_pose(32'hffff_ffff, 16'h0, 16'h0, 16'h0, 16'h0,
             32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff);
    send_sample(32'h8000_0000, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0);
    send_sample(32'hffff_ffff, 0, 0, 5, 6, 7);
    end_burst();
    // minimum threshold, extreme quaternion, zero threshold behavior near
    set_pose(1, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
             32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_sample(1, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(2, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_sample(0, 0, 32'hffff_ffff, 0, 0, 0);
    send_sample(0, 1, 1, 32'h0001_0000, 32'hffff_0000, 32'h0002_0000);
    end_burst();
    // random phases; one includes a long receiver hold-off
    for (int ph = 0; ph < 6; ph++) begin
      th = (ph == 0) ? 32'h1 : $urandom_range(1) ? $urandom_range(32'h40000) : $urandom;
      set_pose(th, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               rnd_val(), rnd_val(), rnd_val());
      calm = (ph == 2);
      if (ph == 3) hold = 300;
      for (int k = 0; k < 150; k++)
        send_sample(rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(),
                    rnd_val());
      end_burst();
    end
    calm = 0;
    repeat (20) @(posedge clk_i);
    $display("sent %0d samples over 9 configurations, %0d contact points checked",
             sent, points);
    if (errors == 0 && pending == 0 && !timeout)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
